[rtl/core/kml_pkg.sv]
package kml_pkg;

  localparam int unsigned MaxPoints   = 1024;
  localparam int unsigned MaxClusters = 16;
  localparam int unsigned MaxDims     = 8;

  localparam int unsigned PidxW = 10;
  localparam int unsigned CidxW = 4;
  localparam int unsigned DidxW = 3;
  localparam int unsigned CoordW = 16;
  localparam int unsigned SumW = 26;
  localparam int unsigned CntW = 11;

  localparam logic [2:0] ReqLoadPoint = 3'd0;
  localparam logic [2:0] ReqLoadCent  = 3'd1;
  localparam logic [2:0] ReqRun       = 3'd2;
  localparam logic [2:0] ReqReadLabel = 3'd3;
  localparam logic [2:0] ReqReadCent  = 3'd4;

  localparam logic [1:0] KindRun   = 2'd0;
  localparam logic [1:0] KindLabel = 2'd1;
  localparam logic [1:0] KindCent  = 2'd2;

  localparam logic [1:0] CfgNumPoints   = 2'd0;
  localparam logic [1:0] CfgNumClusters = 2'd1;
  localparam logic [1:0] CfgNumDims     = 2'd2;
  localparam logic [1:0] CfgMaxIter     = 2'd3;

  typedef enum logic [4:0] {
    S_LCLR, S_IDLE, S_RD_OUT, S_RUN_CHK, S_AS_RD, S_AS_MUL, S_AS_ACC, S_AS_CMP,
    S_AS_LRD, S_AS_LWR, S_IT_END, S_SC, S_UL_RD, S_UL_LAB, S_UP_RD, S_UP_WR,
    S_DV_RD, S_DV_GO, S_DV_WT, S_UPD_END, S_DONE
  } kml_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } kml_div_stat_t;

endpackage

[rtl/core/kml_div.sv]
module kml_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [kml_pkg::SumW-1:0]   dividend_i,
  input  logic        [kml_pkg::CntW-1:0]   divisor_i,
  output kml_pkg::kml_div_stat_t            stat_o,
  output logic signed [kml_pkg::SumW-1:0]   quotient_o
);

  logic                      busy_q, done_q, neg_q;
  logic [4:0]                cnt_q;
  logic [kml_pkg::SumW-1:0]  q_q;
  logic [kml_pkg::CntW:0]    rem_q;
  logic [kml_pkg::CntW-1:0]  div_q;
  logic [kml_pkg::CntW:0]    trial;
  logic                      fits;

  assign trial = {rem_q[kml_pkg::CntW-1:0], q_q[kml_pkg::SumW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(kml_pkg::SumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[kml_pkg::SumW-1];
      q_q   <= dividend_i[kml_pkg::SumW-1] ? -dividend_i : dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial - {1'b0, div_q} : trial;
      q_q   <= {q_q[kml_pkg::SumW-2:0], fits};
    end
  end

  assign quotient_o  = neg_q ? -$signed(q_q) : $signed(q_q);
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

[rtl/core/kmeans_lloyd_clustering.sv]
// Lloyd k-means engine over signed Q8.8 coordinates.
// The input stream carries requests: tuser is the request type, tdata holds
// the item index, the coordinate index and the coordinate value. Loads of
// point and centroid coordinates give no result. A label or centroid read
// gives one result from a registered memory read. A run gives one result
// when it ends; with nonzero point and cluster counts it first clears the
// label memory, then per iteration the assignment pass reads one point and
// one centroid coordinate and accumulates their squared difference before
// the next read, and, when a label changed, the update clears the sum
// memory, sums the points per label by read-modify-write and divides on
// the serial divider. One request is worked on at a time.
// Configuration writes are taken in any cycle but belong to idle periods.
// After reset the label memory is cleared before the first input transfer
// is accepted. The output register holds a result until the receiver takes
// it; loads are still accepted while a result waits.
module kmeans_lloyd_clustering (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // item_index, coord_index, coord_value
  input  logic [2:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // iterations_done, cluster_label, centroid_value
  output logic [1:0]  m_axis_tuser   // result_kind
);

  localparam int unsigned PaW = kml_pkg::PidxW + kml_pkg::DidxW;
  localparam int unsigned CaW = kml_pkg::CidxW + kml_pkg::DidxW;

  logic [10:0] num_points_q;
  logic [4:0]  num_clusters_q;
  logic [3:0]  num_dims_q;
  logic [7:0]  max_iter_q;

  kml_pkg::kml_state_e state_q, state_d;

  logic [kml_pkg::PidxW-1:0] clr_q, i_q;
  logic [kml_pkg::CidxW-1:0] c_q, bc_q, lab_q;
  logic [kml_pkg::DidxW-1:0] j_q;
  logic [7:0]                iter_q;
  logic                      run_q, changed_q;
  logic [31:0]               sq_q;
  logic [34:0]               acc_q, best_q;
  logic [1:0]                rd_kind_q;
  logic                      rd_ok_q;

  logic                      out_valid_q;
  logic [1:0]                out_kind_q;
  logic [7:0]                out_iter_q;
  logic [3:0]                out_label_q;
  logic [15:0]               out_cent_q;

  logic [10:0] n_eff;
  logic [4:0]  kc, k_eff;
  logic [3:0]  d_eff;
  logic [7:0]  limit;
  logic        i_last, c_last, j_last, in_acc, out_free;

  logic [kml_pkg::PidxW-1:0]  item;
  logic [kml_pkg::DidxW-1:0]  coord;
  logic [15:0]                value;

  logic [15:0] pt_mem [2**PaW];
  logic [15:0] cen_mem [2**CaW];
  logic [3:0]  lab_mem [2**kml_pkg::PidxW];
  logic [kml_pkg::SumW-1:0] sum_mem [2**CaW];
  logic [kml_pkg::CntW-1:0] cnt_q [kml_pkg::MaxClusters];

  logic           pt_we, pt_re, cen_we, cen_re, lab_we, lab_re, sum_we, sum_re;
  logic [PaW-1:0] pt_wa, pt_ra;
  logic [CaW-1:0] cen_wa, cen_ra, sum_wa, sum_ra;
  logic [kml_pkg::PidxW-1:0] lab_wa, lab_ra;
  logic [15:0]    pt_rd_q, cen_rd_q, cen_wd;
  logic [3:0]     lab_rd_q, lab_wd;
  logic [kml_pkg::SumW-1:0] sum_rd_q, sum_wd;
  logic [kml_pkg::CidxW-1:0] cnt_ra;
  logic [kml_pkg::CntW-1:0]  cnt_rd;

  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic               div_start;
  kml_pkg::kml_div_stat_t div_stat;
  logic signed [kml_pkg::SumW-1:0] quot;

  assign item  = s_axis_tdata[9:0];
  assign coord = s_axis_tdata[12:10];
  assign value = s_axis_tdata[28:13];

  assign n_eff  = (num_points_q > 11'(kml_pkg::MaxPoints)) ? 11'(kml_pkg::MaxPoints)
                                                            : num_points_q;
  assign kc     = (num_clusters_q > 5'(kml_pkg::MaxClusters)) ? 5'(kml_pkg::MaxClusters)
                                                               : num_clusters_q;
  assign k_eff  = ({6'd0, kc} > n_eff) ? n_eff[4:0] : kc;
  assign d_eff  = (num_dims_q > 4'(kml_pkg::MaxDims)) ? 4'(kml_pkg::MaxDims) : num_dims_q;
  assign limit  = (max_iter_q == 8'd0) ? 8'd1 : max_iter_q;
  assign i_last = ({1'b0, i_q} + 11'd1) == n_eff;
  assign c_last = ({1'b0, c_q} + 5'd1) == k_eff;
  assign j_last = ({1'b0, j_q} + 4'd1) == d_eff;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign diff = $signed({pt_rd_q[15], pt_rd_q}) - $signed({cen_rd_q[15], cen_rd_q});
  assign prod = diff * diff;
  assign cnt_rd = cnt_q[cnt_ra];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q   <= 11'd1;
      num_clusters_q <= 5'd1;
      num_dims_q     <= 4'd1;
      max_iter_q     <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kml_pkg::CfgNumPoints:   num_points_q   <= cfg_data_i;
        kml_pkg::CfgNumClusters: num_clusters_q <= cfg_data_i[4:0];
        kml_pkg::CfgNumDims:     num_dims_q     <= cfg_data_i[3:0];
        kml_pkg::CfgMaxIter:     max_iter_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      kml_pkg::S_LCLR: begin
        if (clr_q == '1) state_d = run_q ? kml_pkg::S_AS_RD : kml_pkg::S_IDLE;
        if (clr_q == '1 && run_q && d_eff == 4'd0) state_d = kml_pkg::S_AS_CMP;
      end
      kml_pkg::S_IDLE: begin
        if (in_acc) begin
          case (s_axis_tuser)
            kml_pkg::ReqRun: state_d = kml_pkg::S_RUN_CHK;
            kml_pkg::ReqReadLabel, kml_pkg::ReqReadCent: state_d = kml_pkg::S_RD_OUT;
            default: ;
          endcase
        end
      end
      kml_pkg::S_RD_OUT: if (out_free) state_d = kml_pkg::S_IDLE;
      kml_pkg::S_RUN_CHK: begin
        if (n_eff == 11'd0 || kc == 5'd0) state_d = kml_pkg::S_DONE;
        else state_d = kml_pkg::S_LCLR;
      end
      kml_pkg::S_AS_RD:  state_d = kml_pkg::S_AS_MUL;
      kml_pkg::S_AS_MUL: state_d = kml_pkg::S_AS_ACC;
      kml_pkg::S_AS_ACC: state_d = j_last ? kml_pkg::S_AS_CMP : kml_pkg::S_AS_RD;
      kml_pkg::S_AS_CMP: begin
        if (c_last) state_d = kml_pkg::S_AS_LRD;
        else state_d = (d_eff == 4'd0) ? kml_pkg::S_AS_CMP : kml_pkg::S_AS_RD;
      end
      kml_pkg::S_AS_LRD: state_d = kml_pkg::S_AS_LWR;
      kml_pkg::S_AS_LWR: begin
        if (i_last) state_d = kml_pkg::S_IT_END;
        else state_d = (d_eff == 4'd0) ? kml_pkg::S_AS_CMP : kml_pkg::S_AS_RD;
      end
      kml_pkg::S_IT_END: state_d = changed_q ? kml_pkg::S_SC : kml_pkg::S_DONE;
      kml_pkg::S_SC:     if (clr_q[CaW-1:0] == '1) state_d = kml_pkg::S_UL_RD;
      kml_pkg::S_UL_RD:  state_d = kml_pkg::S_UL_LAB;
      kml_pkg::S_UL_LAB: begin
        if (d_eff != 4'd0) state_d = kml_pkg::S_UP_RD;
        else if (i_last) state_d = kml_pkg::S_UPD_END;
        else state_d = kml_pkg::S_UL_RD;
      end
      kml_pkg::S_UP_RD: state_d = kml_pkg::S_UP_WR;
      kml_pkg::S_UP_WR: begin
        if (!j_last) state_d = kml_pkg::S_UP_RD;
        else if (i_last) state_d = kml_pkg::S_DV_RD;
        else state_d = kml_pkg::S_UL_RD;
      end
      kml_pkg::S_DV_RD: state_d = kml_pkg::S_DV_GO;
      kml_pkg::S_DV_GO: begin
        if (cnt_rd != '0) state_d = kml_pkg::S_DV_WT;
        else if (j_last && c_last) state_d = kml_pkg::S_UPD_END;
        else state_d = kml_pkg::S_DV_RD;
      end
      kml_pkg::S_DV_WT: begin
        if (div_stat.done) begin
          state_d = (j_last && c_last) ? kml_pkg::S_UPD_END : kml_pkg::S_DV_RD;
        end
      end
      kml_pkg::S_UPD_END: begin
        if (iter_q >= limit) state_d = kml_pkg::S_DONE;
        else state_d = (d_eff == 4'd0) ? kml_pkg::S_AS_CMP : kml_pkg::S_AS_RD;
      end
      kml_pkg::S_DONE: if (out_free) state_d = kml_pkg::S_IDLE;
      default: state_d = kml_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    pt_we = 1'b0; pt_re = 1'b0; cen_we = 1'b0; cen_re = 1'b0;
    lab_we = 1'b0; lab_re = 1'b0; sum_we = 1'b0; sum_re = 1'b0;
    pt_wa  = {item, coord};
    pt_ra  = {i_q, j_q};
    cen_wa = {item[kml_pkg::CidxW-1:0], coord};
    cen_wd = value;
    cen_ra = {c_q, j_q};
    lab_wa = clr_q;
    lab_wd = '0;
    lab_ra = i_q;
    sum_wa = clr_q[CaW-1:0];
    sum_wd = '0;
    sum_ra = {lab_q, j_q};
    cnt_ra = c_q;
    div_start = 1'b0;
    case (state_q)
      kml_pkg::S_LCLR: lab_we = 1'b1;
      kml_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_acc) begin
          case (s_axis_tuser)
            kml_pkg::ReqLoadPoint: pt_we = 1'b1;
            kml_pkg::ReqLoadCent:  cen_we = item < 10'(kml_pkg::MaxClusters);
            kml_pkg::ReqReadLabel: begin
              lab_re = 1'b1;
              lab_ra = item;
            end
            kml_pkg::ReqReadCent: begin
              cen_re = 1'b1;
              cen_ra = {item[kml_pkg::CidxW-1:0], coord};
            end
            default: ;
          endcase
        end
      end
      kml_pkg::S_AS_RD: begin
        pt_re  = 1'b1;
        cen_re = 1'b1;
      end
      kml_pkg::S_AS_LRD: lab_re = 1'b1;
      kml_pkg::S_AS_LWR: begin
        lab_we = lab_rd_q != bc_q;
        lab_wa = i_q;
        lab_wd = bc_q;
      end
      kml_pkg::S_SC:    sum_we = 1'b1;
      kml_pkg::S_UL_RD: lab_re = 1'b1;
      kml_pkg::S_UL_LAB: cnt_ra = lab_rd_q;
      kml_pkg::S_UP_RD: begin
        pt_re  = 1'b1;
        sum_re = 1'b1;
      end
      kml_pkg::S_UP_WR: begin
        sum_we = 1'b1;
        sum_wa = {lab_q, j_q};
        sum_wd = sum_rd_q + {{(kml_pkg::SumW-16){pt_rd_q[15]}}, pt_rd_q};
      end
      kml_pkg::S_DV_RD: begin
        sum_re = 1'b1;
        sum_ra = {c_q, j_q};
      end
      kml_pkg::S_DV_GO: begin
        div_start = cnt_rd != '0;
        cen_we = cnt_rd == '0;
        cen_wa = {c_q, j_q};
        cen_wd = '0;
      end
      kml_pkg::S_DV_WT: begin
        cen_we = div_stat.done;
        cen_wa = {c_q, j_q};
        cen_wd = quot[15:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[pt_wa] <= value;
    if (pt_re) pt_rd_q <= pt_mem[pt_ra];
    if (cen_we) cen_mem[cen_wa] <= cen_wd;
    if (cen_re) cen_rd_q <= cen_mem[cen_ra];
    if (lab_we) lab_mem[lab_wa] <= lab_wd;
    if (lab_re) lab_rd_q <= lab_mem[lab_ra];
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    if (sum_re) sum_rd_q <= sum_mem[sum_ra];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      kml_pkg::S_IDLE: begin
        rd_kind_q <= (s_axis_tuser == kml_pkg::ReqReadLabel) ? kml_pkg::KindLabel
                                                            : kml_pkg::KindCent;
        rd_ok_q   <= item < 10'(kml_pkg::MaxClusters);
      end
      kml_pkg::S_AS_RD: ;
      kml_pkg::S_AS_MUL: sq_q <= prod[31:0];
      kml_pkg::S_AS_ACC: acc_q <= acc_q + {3'd0, sq_q};
      kml_pkg::S_AS_CMP: begin
        if (c_q == '0 || acc_q < best_q) begin
          best_q <= acc_q;
          bc_q   <= c_q;
        end
        acc_q <= '0;
      end
      kml_pkg::S_SC: begin
        if (clr_q[CaW-1:kml_pkg::CidxW] == '0) cnt_q[clr_q[kml_pkg::CidxW-1:0]] <= '0;
      end
      kml_pkg::S_UL_LAB: begin
        lab_q <= lab_rd_q;
        cnt_q[lab_rd_q] <= cnt_rd + kml_pkg::CntW'(1);
      end
      default: begin
        acc_q <= '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= kml_pkg::S_LCLR;
      clr_q     <= '0;
      i_q       <= '0;
      c_q       <= '0;
      j_q       <= '0;
      iter_q    <= '0;
      run_q     <= 1'b0;
      changed_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        kml_pkg::S_LCLR: clr_q <= clr_q + 1'b1;
        kml_pkg::S_RUN_CHK: begin
          iter_q <= '0;
          run_q  <= 1'b1;
          clr_q  <= '0;
        end
        kml_pkg::S_AS_ACC: j_q <= j_q + 1'b1;
        kml_pkg::S_AS_CMP: begin
          j_q <= '0;
          c_q <= c_q + 1'b1;
        end
        kml_pkg::S_AS_LWR: begin
          c_q <= '0;
          i_q <= i_q + 1'b1;
          if (lab_rd_q != bc_q) changed_q <= 1'b1;
        end
        kml_pkg::S_IT_END: begin
          iter_q <= iter_q + 8'd1;
          clr_q  <= '0;
          i_q    <= '0;
        end
        kml_pkg::S_SC: clr_q <= clr_q + 1'b1;
        kml_pkg::S_UL_LAB: begin
          j_q <= '0;
          if (d_eff == 4'd0) i_q <= i_q + 1'b1;
        end
        kml_pkg::S_UP_WR: begin
          j_q <= j_q + 1'b1;
          if (j_last) begin
            i_q <= i_q + 1'b1;
            if (i_last) begin
              j_q <= '0;
              c_q <= '0;
            end
          end
        end
        kml_pkg::S_DV_GO, kml_pkg::S_DV_WT: begin
          if (state_q == kml_pkg::S_DV_GO ? cnt_rd == '0 : div_stat.done) begin
            j_q <= j_q + 1'b1;
            if (j_last) begin
              j_q <= '0;
              c_q <= c_q + 1'b1;
            end
          end
        end
        kml_pkg::S_UPD_END: begin
          i_q <= '0;
          c_q <= '0;
          j_q <= '0;
          changed_q <= 1'b0;
        end
        kml_pkg::S_DONE: run_q <= 1'b0;
        default: ;
      endcase
      if (state_q == kml_pkg::S_LCLR && clr_q == '1) begin
        i_q <= '0;
        c_q <= '0;
        j_q <= '0;
        changed_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == kml_pkg::S_RD_OUT || state_q == kml_pkg::S_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (state_q == kml_pkg::S_RD_OUT) begin
        out_kind_q  <= rd_kind_q;
        out_iter_q  <= iter_q;
        out_label_q <= (rd_kind_q == kml_pkg::KindLabel) ? lab_rd_q : 4'd0;
        out_cent_q  <= (rd_kind_q == kml_pkg::KindCent && rd_ok_q) ? cen_rd_q : 16'd0;
      end else if (state_q == kml_pkg::S_DONE) begin
        out_kind_q  <= kml_pkg::KindRun;
        out_iter_q  <= iter_q;
        out_label_q <= '0;
        out_cent_q  <= '0;
      end
    end
  end

  kml_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ($signed(sum_rd_q)),
    .divisor_i  (cnt_rd),
    .stat_o     (div_stat),
    .quotient_o (quot)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {4'd0, out_cent_q, out_label_q, out_iter_q};

`ifndef ASSERT_OFF
  a_div_only_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> state_q == kml_pkg::S_DV_WT)
    else $error("divider busy outside of the divide wait state");

  a_cen_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cen_we |-> (state_q == kml_pkg::S_IDLE || state_q == kml_pkg::S_DV_GO ||
                state_q == kml_pkg::S_DV_WT))
    else $error("centroid memory written outside of load or update");

  a_label_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == kml_pkg::S_AS_LWR |-> {1'b0, bc_q} < k_eff)
    else $error("assigned label beyond the cluster count");

  a_run_result_iters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == kml_pkg::S_DONE |-> iter_q <= limit)
    else $error("iteration count beyond the limit");
`endif

endmodule
